// ----- rtl/core/lcdbg_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdbg_pkg
// Shared types, controller byte codes and the 5x7 font table for the LCD
// text command byte generator.
// ----------------------------------------------------------------------------
package lcdbg_pkg;

    // Font store geometry: one row per printable code, five columns of 8 bits.
    localparam int GLYPH_COLS = 5;
    localparam int FONT_DEPTH = 96;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);
    localparam int FONT_W     = 8 * GLYPH_COLS;
    localparam int STEP_W     = 3;

    // Request function codes.
    typedef enum logic [2:0] {
        FUNC_CHAR     = 3'd0,
        FUNC_CURSOR   = 3'd1,
        FUNC_CONTRAST = 3'd2,
        FUNC_RAW_DATA = 3'd3,
        FUNC_RAW_CMD  = 3'd4
    } func_t;

    // Character codes with special handling.
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_SUBST = 8'h3f;

    // Controller bytes.
    localparam logic [7:0] BYTE_BLANK = 8'h00;
    localparam logic [7:0] CMD_EXT    = 8'h21;
    localparam logic [7:0] CMD_BASIC  = 8'h20;
    localparam logic [7:0] CMD_SET_X  = 8'h80;
    localparam logic [7:0] CMD_SET_Y  = 8'h40;
    localparam logic [7:0] CMD_VOP    = 8'h80;
    localparam logic [7:0] VOP_MASK   = 8'h7f;

    // Glyph steps of a character item: blank, five columns, blank.
    localparam logic [STEP_W-1:0] STEP_CHAR_LAST = 3'd6;

    // Font table, first column in the top byte, codes 0x20 to 0x7f.
    localparam logic [FONT_W-1:0] FONT_ROM [FONT_DEPTH] = '{
        40'h00_00_00_00_00, 40'h00_00_5f_00_00, 40'h00_07_00_07_00, 40'h14_7f_14_7f_14,
        40'h24_2a_7f_2a_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
        40'h00_1c_22_41_00, 40'h00_41_22_1c_00, 40'h14_08_3e_08_14, 40'h08_08_3e_08_08,
        40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
        40'h3e_51_49_45_3e, 40'h00_42_7f_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4b_31,
        40'h18_14_12_7f_10, 40'h27_45_45_45_39, 40'h3c_4a_49_49_30, 40'h01_71_09_05_03,
        40'h36_49_49_49_36, 40'h06_49_49_29_1e, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
        40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
        40'h32_49_79_41_3e, 40'h7e_11_11_11_7e, 40'h7f_49_49_49_36, 40'h3e_41_41_41_22,
        40'h7f_41_41_22_1c, 40'h7f_49_49_49_41, 40'h7f_09_09_09_01, 40'h3e_41_49_49_7a,
        40'h7f_08_08_08_7f, 40'h00_41_7f_41_00, 40'h20_40_41_3f_01, 40'h7f_08_14_22_41,
        40'h7f_40_40_40_40, 40'h7f_02_0c_02_7f, 40'h7f_04_08_10_7f, 40'h3e_41_41_41_3e,
        40'h7f_09_09_09_06, 40'h3e_41_51_21_5e, 40'h7f_09_19_29_46, 40'h46_49_49_49_31,
        40'h01_01_7f_01_01, 40'h3f_40_40_40_3f, 40'h1f_20_40_20_1f, 40'h3f_40_38_40_3f,
        40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7f_41_41_00,
        40'h02_04_08_10_20, 40'h00_41_41_7f_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
        40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7f_48_44_44_38, 40'h38_44_44_44_20,
        40'h38_44_44_48_7f, 40'h38_54_54_54_18, 40'h08_7e_09_01_02, 40'h0c_52_52_52_3e,
        40'h7f_08_04_04_78, 40'h00_44_7d_40_00, 40'h20_40_44_3d_00, 40'h7f_10_28_44_00,
        40'h00_41_7f_40_00, 40'h7c_04_18_04_78, 40'h7c_08_04_04_78, 40'h38_44_44_44_38,
        40'h7c_14_14_14_08, 40'h08_14_14_18_7c, 40'h7c_08_04_04_08, 40'h48_54_54_54_20,
        40'h04_3f_44_40_20, 40'h3c_40_40_20_7c, 40'h1c_20_40_20_1c, 40'h3c_40_30_40_3c,
        40'h44_28_10_28_44, 40'h0c_50_50_50_3c, 40'h44_64_54_4c_44, 40'h00_08_36_41_00,
        40'h00_00_7f_00_00, 40'h00_41_36_08_00, 40'h10_08_08_10_08, 40'h00_06_09_09_06
    };

endpackage

// ----- rtl/core/lcdbg_ram.sv -----
// ----------------------------------------------------------------------------
// lcdbg_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module lcdbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/lcd_text_command_byte_generator.sv -----
// ----------------------------------------------------------------------------
// lcd_text_command_byte_generator
// Turns display requests into tagged command and data bytes for a
// column-addressed monochrome LCD controller, with glyphs from a font RAM.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_stall  func, value, column, row
//  rsp      out        rsp_valid/rsp_stall  is_data, out_byte, last
//
// One result byte leaves per cycle while rsp_stall is low: a character
// item gives 7 bytes, a contrast item 3, a cursor item 2 and a raw byte 1;
// items that give no bytes never occupy the byte sequencer.
// After reset the font RAM is loaded from the package table, one glyph a
// cycle, until all 96 glyphs are written; req_stall stays high until then.
// The glyph is read from the font RAM as the item is accepted and holds
// for the whole item. A new item is taken in the cycle its predecessor
// hands over its last byte, and rsp_stall holds the output register.
//
module lcd_text_command_byte_generator
    import lcdbg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [2:0] func,
    input  logic [7:0] value,
    input  logic [6:0] column,
    input  logic [2:0] row,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic       is_data,
    output logic [7:0] out_byte,
    output logic       last
);

    logic               fill_done_reg, fill_done_next;
    logic [FONT_AW-1:0] fill_cnt_reg, fill_cnt_next;

    logic               job_valid_reg, job_valid_next;
    func_t              job_func_reg;
    logic [7:0]         job_value_reg;
    logic [6:0]         job_column_reg;
    logic [2:0]         job_row_reg;
    logic [STEP_W-1:0]  job_step_reg, job_step_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic               is_data_reg;
    logic [7:0]         out_byte_reg;
    logic               last_reg;

    func_t              req_func;
    logic               req_accept;
    logic               req_has_bytes;
    logic               req_is_ctrl;
    logic [7:0]         char_code;
    logic [7:0]         glyph_index;
    logic [FONT_W-1:0]  glyph_row;

    logic               job_emit;
    logic               step_is_data;
    logic [7:0]         step_byte;
    logic               step_last;

    // Font RAM: loaded once after reset, then read once per accepted item.
    lcdbg_ram #(
        .WIDTH (FONT_W),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .clk     (clk),
        .wr_en   (!fill_done_reg),
        .wr_addr (fill_cnt_reg),
        .wr_data (FONT_ROM[fill_cnt_reg]),
        .rd_en   (req_accept),
        .rd_addr (glyph_index[FONT_AW-1:0]),
        .rd_data (glyph_row)
    );

    // Font load counter.
    always_comb
    begin
        fill_cnt_next  = fill_cnt_reg;
        fill_done_next = fill_done_reg;
        if (!fill_done_reg)
        begin
            if (fill_cnt_reg == FONT_AW'(FONT_DEPTH - 1))
            begin
                fill_done_next = 1'b1;
            end
            else
            begin
                fill_cnt_next = fill_cnt_reg + 1'b1;
            end
        end
    end

    // Request decode: printable code mapping and whether any byte follows.
    assign req_func    = func_t'(func);
    assign req_is_ctrl = (value == CHAR_TAB) || (value == CHAR_LF) || (value == CHAR_CR);
    assign char_code   = ((value < CHAR_FIRST) || value[7]) ? CHAR_SUBST : value;
    assign glyph_index = char_code - CHAR_FIRST;

    always_comb
    begin
        unique case (req_func)
            FUNC_CHAR:
            begin
                req_has_bytes = !req_is_ctrl;
            end
            FUNC_CURSOR, FUNC_CONTRAST, FUNC_RAW_DATA, FUNC_RAW_CMD:
            begin
                req_has_bytes = 1'b1;
            end
            default:
            begin
                req_has_bytes = 1'b0;
            end
        endcase
    end

    // Byte of the current step of the held item.
    always_comb
    begin
        step_is_data = 1'b0;
        step_byte    = BYTE_BLANK;
        step_last    = 1'b0;
        unique case (job_func_reg)
            FUNC_CHAR:
            begin
                step_is_data = 1'b1;
                step_last    = (job_step_reg == STEP_CHAR_LAST);
                case (job_step_reg)
                    3'd1:    step_byte = glyph_row[39:32];
                    3'd2:    step_byte = glyph_row[31:24];
                    3'd3:    step_byte = glyph_row[23:16];
                    3'd4:    step_byte = glyph_row[15:8];
                    3'd5:    step_byte = glyph_row[7:0];
                    default: step_byte = BYTE_BLANK;
                endcase
            end
            FUNC_CURSOR:
            begin
                if (job_step_reg == 3'd0)
                begin
                    step_byte = CMD_SET_X | {1'b0, job_column_reg};
                end
                else
                begin
                    step_byte = CMD_SET_Y | {5'd0, job_row_reg};
                    step_last = 1'b1;
                end
            end
            FUNC_CONTRAST:
            begin
                case (job_step_reg)
                    3'd0:    step_byte = CMD_EXT;
                    3'd1:    step_byte = CMD_VOP | (job_value_reg & VOP_MASK);
                    default:
                    begin
                        step_byte = CMD_BASIC;
                        step_last = 1'b1;
                    end
                endcase
            end
            FUNC_RAW_DATA:
            begin
                step_is_data = 1'b1;
                step_byte    = job_value_reg;
                step_last    = 1'b1;
            end
            default:
            begin
                step_byte = job_value_reg;
                step_last = 1'b1;
            end
        endcase
    end

    // Handshake: the held item moves a byte whenever the output register frees.
    assign job_emit   = job_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = !fill_done_reg || (job_valid_reg && !(job_emit && step_last));
    assign req_accept = req_valid && !req_stall;

    // Sequencer next state.
    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_step_next  = job_step_reg;
        if (job_emit)
        begin
            job_step_next = job_step_reg + 1'b1;
            if (step_last)
            begin
                job_valid_next = 1'b0;
            end
        end
        if (req_accept && req_has_bytes)
        begin
            job_valid_next = 1'b1;
            job_step_next  = '0;
        end
    end

    // Output register valid.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (job_emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_done_reg <= 1'b0;
            fill_cnt_reg  <= '0;
            job_valid_reg <= 1'b0;
            job_step_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_done_reg <= fill_done_next;
            fill_cnt_reg  <= fill_cnt_next;
            job_valid_reg <= job_valid_next;
            job_step_reg  <= job_step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers of the held item.
    always_ff @(posedge clk)
    begin
        if (req_accept && req_has_bytes)
        begin
            job_func_reg   <= req_func;
            job_value_reg  <= value;
            job_column_reg <= column;
            job_row_reg    <= row;
        end
    end

    // Payload registers of the output item.
    always_ff @(posedge clk)
    begin
        if (job_emit)
        begin
            is_data_reg  <= step_is_data;
            out_byte_reg <= step_byte;
            last_reg     <= step_last;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign is_data   = is_data_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

// ----- rtl/core/lcdbg_checker.sv -----
// ----------------------------------------------------------------------------
// lcdbg_checker
// Port-level assertions for the LCD text command byte generator.
// ----------------------------------------------------------------------------
module lcdbg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_stall,
    input logic [2:0] func,
    input logic [7:0] value,
    input logic [6:0] column,
    input logic [2:0] row,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input logic       is_data,
    input logic [7:0] out_byte,
    input logic       last
);

    // A stalled request item holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(func) && $stable(value)
            && $stable(column) && $stable(row))
    else $error("stalled request item changed");

    // A stalled output item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(out_byte) && $stable(is_data)
            && $stable(last))
    else $error("stalled output item changed");

    // A glyph keeps streaming data bytes until its last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && is_data && !last |=> rsp_valid && is_data)
    else $error("glyph byte run broken");

    // A command sequence keeps streaming command bytes until its last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && !is_data && !last |=> rsp_valid && !is_data)
    else $error("command byte run broken");

    // No new request is taken while a stalled sequence still has bytes to go.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall && !last |-> req_stall)
    else $error("request taken in the middle of a sequence");

endmodule

bind lcd_text_command_byte_generator lcdbg_checker u_lcdbg_checker (.*);
